// ===== sv/g2e_pkg.sv =====
// shared types, constants and helper functions for the geodetic to local enu block
// elaboration-time functions build the arctangent, cordic gain and ellipsoid constants
// no dependencies
package g2e_pkg;

    localparam int ANGLE_FRAC_BITS_DEF = 23;
    localparam int CORDIC_STAGES_DEF   = 32;
    localparam int TRIG_FRAC           = 60;
    localparam int LEN_FRAC            = 16;
    localparam int TOP_STAGES          = 6;

    // ellipsoid, millimetres
    localparam logic [63:0] SEMI_MAJOR_MM = 64'd6378137000;
    localparam logic [63:0] E2_NUM        = 64'd595514000;
    localparam logic [63:0] E2_DEN        = 64'd88957238049;
    localparam logic [63:0] DIV_HI        = SEMI_MAJOR_MM << 12;

    // reciprocal of 360 for the whole-degree part of an angle
    localparam int          MOD_SHIFT   = 24;
    localparam int          MOD_RECIP_W = 16;
    localparam logic [15:0] MOD_RECIP   = 16'd46604;

    // register indexes
    localparam logic [1:0] REG_ANCHOR_LON    = 2'd0;
    localparam logic [1:0] REG_ANCHOR_LAT    = 2'd1;
    localparam logic [1:0] REG_ANCHOR_HEIGHT = 2'd2;

    typedef struct packed {
        logic        neg;
        logic [63:0] p00;
        logic [63:0] p01;
        logic [63:0] p10;
        logic [63:0] p11;
    } t_pp;

    typedef struct packed {
        logic signed [63:0] sl;
        logic signed [63:0] cl;
        logic signed [63:0] so;
        logic signed [63:0] co;
    } t_trig;

    typedef struct packed {
        logic signed [63:0] x;
        logic signed [63:0] y;
        logic signed [63:0] z;
    } t_vec;

    // first half of a rounded product: sign and four 32x32 partial products
    function automatic t_pp f_mul_pp(input logic signed [63:0] a, input logic signed [63:0] b);
        logic [63:0] ma;
        logic [63:0] mb;
        t_pp         p;
        ma = a[63] ? 64'(-a) : 64'(a);
        mb = b[63] ? 64'(-b) : 64'(b);
        p.neg = a[63] ^ b[63];
        p.p00 = {32'b0, ma[31:0]}  * {32'b0, mb[31:0]};
        p.p01 = {32'b0, ma[31:0]}  * {32'b0, mb[63:32]};
        p.p10 = {32'b0, ma[63:32]} * {32'b0, mb[31:0]};
        p.p11 = {32'b0, ma[63:32]} * {32'b0, mb[63:32]};
        return p;
    endfunction

    // second half: sum, round half away from zero, shift, apply sign
    function automatic logic signed [63:0] f_mul_fin(input t_pp p, input int s);
        logic [127:0] acc;
        logic [63:0]  r;
        acc = {p.p11, 64'b0} + {32'b0, p.p01, 32'b0} + {32'b0, p.p10, 32'b0}
            + {64'b0, p.p00} + (128'd1 << (s - 1));
        r = 64'(acc >> s);
        return p.neg ? 64'(-r) : r;
    endfunction

    // elaboration only: low 64 bits of floor(num / d)
    function automatic logic [63:0] f_div128(input logic [127:0] num, input logic [63:0] d);
        logic [64:0] rem;
        logic [63:0] q;
        rem = '0;
        q   = '0;
        if (d == 64'd0) begin
            return '1;
        end
        for (int i = 127; i >= 0; i--) begin
            rem = {rem[63:0], num[i]};
            q   = {q[62:0], 1'b0};
            if (rem >= {1'b0, d}) begin
                rem  = rem - {1'b0, d};
                q[0] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic longint f_udiv(input longint a, input longint b);
        return longint'(f_div128({64'b0, 64'(a)}, 64'(b)));
    endfunction

    function automatic logic [63:0] f_isqrt128(input logic [127:0] x);
        logic [63:0] r;
        logic [63:0] t;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            t = r | (64'd1 << b);
            if (({64'b0, t} * {64'b0, t}) <= x) begin
                r = t;
            end
        end
        return r;
    endfunction

    function automatic longint f_atan_inv(input longint n);
        longint p;
        longint sum;
        longint k;
        longint t;
        p   = f_udiv(longint'(1) << TRIG_FRAC, n);
        sum = 0;
        k   = 0;
        for (int it = 0; it < 64; it++) begin
            if (p != 0) begin
                t   = f_udiv(p, 2 * k + 1);
                sum = k[0] ? sum - t : sum + t;
                p   = f_udiv(p, n * n);
                k   = k + 1;
            end
        end
        return sum;
    endfunction

    // atan(2^-i) in Q60, entry 0 is pi/4
    function automatic longint f_atan_rom(input int i);
        longint sum;
        longint k;
        longint t;
        int     e;
        sum = 0;
        k   = 0;
        e   = TRIG_FRAC - i;
        if (i == 0) begin
            return 4 * f_atan_inv(5) - f_atan_inv(239);
        end
        for (int it = 0; it < 64; it++) begin
            if (e >= 0) begin
                t   = f_udiv(longint'(1) << e, 2 * k + 1);
                sum = k[0] ? sum - t : sum + t;
                k   = k + 1;
                e   = TRIG_FRAC - i * int'(2 * k + 1);
            end
        end
        return sum;
    endfunction

    function automatic logic [63:0] f_cordic_k(input int stages);
        logic [63:0] g;
        logic [63:0] sg;
        g = 64'd1 << TRIG_FRAC;
        for (int i = 0; i < stages; i++) begin
            if (2 * i < 64) begin
                g = g + (g >> (2 * i));
            end
        end
        sg = f_isqrt128({64'b0, g} << 60);
        return f_div128(128'd1 << 120, sg);
    endfunction

    function automatic int f_ecef_lat(input int stages);
        return 141 + stages;
    endfunction

    localparam longint             ATAN_PI4    = f_atan_rom(0);
    localparam logic signed [63:0] RAD_PER_DEG = 64'((4 * ATAN_PI4) / 180);
    localparam logic signed [63:0] ECC2        = f_div128({64'b0, E2_NUM} << 60, E2_DEN);
    localparam logic [63:0]        ONE_Q60     = 64'd1 << TRIG_FRAC;

endpackage

// ===== sv/g2e_ecef.sv =====
// geodetic point to earth-centred vector, fully pipelined, one word per cycle while i_en is high
// angle reduction, two cordic lanes, 64-step root and 64-step divide for the normal radius
// depends on g2e_pkg
module g2e_ecef import g2e_pkg::*; #(
    parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF,
    parameter int CORDIC_STAGES   = CORDIC_STAGES_DEF
) (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic signed [31:0] i_lon,
    input  logic signed [30:0] i_lat,
    input  logic signed [31:0] i_height,
    output t_vec               o_vec,
    output t_trig              o_trig
);

    localparam int XW = 32 - ANGLE_FRAC_BITS;
    localparam int PW = XW + MOD_RECIP_W;
    localparam int RW = ANGLE_FRAC_BITS + 10;
    localparam int CS = CORDIC_STAGES;
    localparam longint FULL_L = 360 * (longint'(1) << ANGLE_FRAC_BITS);
    localparam logic signed [RW-1:0] FULL    = RW'(FULL_L);
    localparam logic signed [RW-1:0] HALF    = RW'(FULL_L / 2);
    localparam logic signed [RW-1:0] QUARTER = RW'(FULL_L / 4);
    localparam logic signed [63:0]   CORDIC_K = f_cordic_k(CORDIC_STAGES);

    // lane 0 is latitude, lane 1 longitude
    logic signed [31:0] ang [0:1];
    assign ang[0] = {i_lat[30], i_lat};
    assign ang[1] = i_lon;

    logic                r_p1_neg  [0:1];
    logic [XW-1:0]       r_p1_x    [0:1];
    logic [ANGLE_FRAC_BITS-1:0] r_p1_low [0:1];
    logic [PW-1:0]       r_p1_prod [0:1];
    logic signed [RW-1:0] r_p2_r   [0:1];
    logic signed [RW-1:0] r_p3_r   [0:1];
    logic                r_p3_flip [0:1];
    t_pp                 r_p4_pp   [0:1];
    logic                r_p4_flip [0:1];
    logic signed [31:0]  r_p1_h, r_p2_h, r_p3_h, r_p4_h;

    logic signed [63:0]  r_cx [0:1][0:CS];
    logic signed [63:0]  r_cy [0:1][0:CS];
    logic signed [63:0]  r_cz [0:1][0:CS-1];
    logic                r_cf [0:1][0:CS];
    logic signed [31:0]  r_ch [0:CS];

    for (genvar k = 0; k < 2; k++) begin : g_lane
        logic [31:0]          mag;
        logic [PW-1:0]        q;
        logic [XW-1:0]        remx;
        logic signed [RW-1:0] md;
        logic signed [RW-1:0] f1;
        logic signed [RW-1:0] f2;
        logic                 flip;

        assign mag  = ang[k][31] ? 32'(-ang[k]) : 32'(ang[k]);
        assign q    = r_p1_prod[k] >> MOD_SHIFT;
        assign remx = r_p1_x[k] - XW'(q * PW'(360));
        assign md   = (RW'(remx) << ANGLE_FRAC_BITS) | RW'(r_p1_low[k]);

        always_comb begin
            f1   = r_p2_r[k];
            flip = 1'b0;
            if (f1 > HALF) begin
                f1 = f1 - FULL;
            end else if (f1 <= -HALF) begin
                f1 = f1 + FULL;
            end
            f2 = f1;
            if (f1 > QUARTER) begin
                f2   = HALF - f1;
                flip = 1'b1;
            end else if (f1 < -QUARTER) begin
                f2   = -HALF - f1;
                flip = 1'b1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_p1_neg[k]  <= ang[k][31];
                r_p1_x[k]    <= mag[31:ANGLE_FRAC_BITS];
                r_p1_low[k]  <= mag[ANGLE_FRAC_BITS-1:0];
                r_p1_prod[k] <= PW'(mag[31:ANGLE_FRAC_BITS]) * PW'(MOD_RECIP);
                r_p2_r[k]    <= r_p1_neg[k] ? -md : md;
                r_p3_r[k]    <= f2;
                r_p3_flip[k] <= flip;
                r_p4_pp[k]   <= f_mul_pp({{(64-RW){r_p3_r[k][RW-1]}}, r_p3_r[k]}, RAD_PER_DEG);
                r_p4_flip[k] <= r_p3_flip[k];
                r_cx[k][0]   <= CORDIC_K;
                r_cy[k][0]   <= '0;
                r_cz[k][0]   <= f_mul_fin(r_p4_pp[k], ANGLE_FRAC_BITS);
                r_cf[k][0]   <= r_p4_flip[k];
            end
        end

        for (genvar i = 0; i < CS; i++) begin : g_rot
            localparam logic signed [63:0] AT = 64'(f_atan_rom(i));
            logic signed [63:0] zi;
            assign zi = (i == 0) ? r_cz[k][0] : r_cz[k][(i == 0) ? 0 : i];
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    if (zi >= 0) begin
                        r_cx[k][i+1] <= r_cx[k][i] - (r_cy[k][i] >>> i);
                        r_cy[k][i+1] <= r_cy[k][i] + (r_cx[k][i] >>> i);
                    end else begin
                        r_cx[k][i+1] <= r_cx[k][i] + (r_cy[k][i] >>> i);
                        r_cy[k][i+1] <= r_cy[k][i] - (r_cx[k][i] >>> i);
                    end
                    r_cf[k][i+1] <= r_cf[k][i];
                end
            end
            if (i < CS - 1) begin : g_z
                always_ff @(posedge i_clk) begin
                    if (i_en) begin
                        r_cz[k][i+1] <= (zi >= 0) ? zi - AT : zi + AT;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p1_h   <= i_height;
            r_p2_h   <= r_p1_h;
            r_p3_h   <= r_p2_h;
            r_p4_h   <= r_p3_h;
            r_ch[0]  <= r_p4_h;
        end
    end

    for (genvar i = 0; i < CS; i++) begin : g_hc
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_ch[i+1] <= r_ch[i];
            end
        end
    end

    // sin/cos out, then w = 1 - e2 sin^2 lat
    t_trig              r_p6_trig, r_p7_trig, r_p8_trig, r_p9_trig;
    t_pp                r_p6_pp, r_p8_pp;
    logic signed [63:0] r_p7_ssq, r_p9_t;
    logic signed [31:0] r_p6_h, r_p7_h, r_p8_h, r_p9_h;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p6_trig.sl <= r_cy[0][CS];
            r_p6_trig.cl <= r_cf[0][CS] ? -r_cx[0][CS] : r_cx[0][CS];
            r_p6_trig.so <= r_cy[1][CS];
            r_p6_trig.co <= r_cf[1][CS] ? -r_cx[1][CS] : r_cx[1][CS];
            r_p6_pp      <= f_mul_pp(r_cy[0][CS], r_cy[0][CS]);
            r_p6_h       <= r_ch[CS];
            r_p7_ssq     <= f_mul_fin(r_p6_pp, TRIG_FRAC);
            r_p7_trig    <= r_p6_trig;
            r_p7_h       <= r_p6_h;
            r_p8_pp      <= f_mul_pp(ECC2, r_p7_ssq);
            r_p8_trig    <= r_p7_trig;
            r_p8_h       <= r_p7_h;
            r_p9_t       <= f_mul_fin(r_p8_pp, TRIG_FRAC);
            r_p9_trig    <= r_p8_trig;
            r_p9_h       <= r_p8_h;
        end
    end

    // root of w * 2^60, one result bit per stage
    logic [63:0]        sq_w0;
    logic [65:0]        r_qrem  [1:63];
    logic [63:0]        r_qw    [1:63];
    logic [63:0]        r_qroot [1:64];
    t_trig              r_qtrig [1:64];
    logic signed [31:0] r_qh    [1:64];

    assign sq_w0 = ONE_Q60 - 64'(r_p9_t);

    for (genvar j = 0; j < 64; j++) begin : g_sqrt
        logic [65:0]        rem_in;
        logic [63:0]        root_in;
        logic [63:0]        w_in;
        t_trig              trig_in;
        logic signed [31:0] h_in;
        logic [127:0]       xs;
        logic [67:0]        rem2;
        logic [67:0]        trial;
        logic               ge;
        if (j == 0) begin : g_src0
            assign rem_in  = '0;
            assign root_in = '0;
            assign w_in    = sq_w0;
            assign trig_in = r_p9_trig;
            assign h_in    = r_p9_h;
        end else begin : g_srcn
            assign rem_in  = r_qrem[j];
            assign root_in = r_qroot[j];
            assign w_in    = r_qw[j];
            assign trig_in = r_qtrig[j];
            assign h_in    = r_qh[j];
        end
        assign xs    = {w_in, 64'b0} >> 4;
        assign rem2  = {rem_in, xs[127-2*j -: 2]};
        assign trial = {2'b0, root_in, 2'b01};
        assign ge    = rem2 >= trial;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_qroot[j+1] <= {root_in[62:0], ge};
                r_qtrig[j+1] <= trig_in;
                r_qh[j+1]    <= h_in;
            end
        end
        if (j < 63) begin : g_keep
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_qrem[j+1] <= ge ? 66'(rem2 - trial) : rem2[65:0];
                    r_qw[j+1]   <= w_in;
                end
            end
        end
    end

    // normal radius n = a * 2^76 / root, one quotient bit per stage
    logic [63:0]        r_drem  [1:63];
    logic [63:0]        r_dd    [1:63];
    logic [63:0]        r_dq    [1:64];
    t_trig              r_dtrig [1:64];
    logic signed [31:0] r_dh    [1:64];

    for (genvar j = 0; j < 64; j++) begin : g_div
        logic [63:0]        rem_in;
        logic [63:0]        d_in;
        logic [63:0]        q_in;
        t_trig              trig_in;
        logic signed [31:0] h_in;
        logic [64:0]        rem2;
        logic               ge;
        if (j == 0) begin : g_src0
            assign rem_in  = DIV_HI;
            assign d_in    = r_qroot[64];
            assign q_in    = '0;
            assign trig_in = r_qtrig[64];
            assign h_in    = r_qh[64];
        end else begin : g_srcn
            assign rem_in  = r_drem[j];
            assign d_in    = r_dd[j];
            assign q_in    = r_dq[j];
            assign trig_in = r_dtrig[j];
            assign h_in    = r_dh[j];
        end
        assign rem2 = {rem_in, 1'b0};
        assign ge   = rem2 >= {1'b0, d_in};
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_dq[j+1]    <= {q_in[62:0], ge};
                r_dtrig[j+1] <= trig_in;
                r_dh[j+1]    <= h_in;
            end
        end
        if (j < 63) begin : g_keep
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_drem[j+1] <= ge ? 64'(rem2 - {1'b0, d_in}) : rem2[63:0];
                    r_dd[j+1]   <= d_in;
                end
            end
        end
    end

    // x, y, z from n and height
    logic signed [63:0] m1_n, m1_hq;
    t_pp                r_m1_pa, r_m1_pb;
    logic signed [63:0] r_m1_n, r_m1_hq, r_m2_n, r_m2_hq, r_m2_ne, r_m2_ncl;
    t_trig              r_m1_trig, r_m2_trig, r_m3_trig, r_m4_trig;
    t_pp                r_m3_p0, r_m3_p1, r_m3_p2;
    t_vec               r_m4_vec;

    assign m1_n  = r_dq[64];
    assign m1_hq = {{16{r_dh[64][31]}}, r_dh[64], 16'b0};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m1_pa   <= f_mul_pp(m1_n, ECC2);
            r_m1_pb   <= f_mul_pp(m1_n + m1_hq, r_dtrig[64].cl);
            r_m1_n    <= m1_n;
            r_m1_hq   <= m1_hq;
            r_m1_trig <= r_dtrig[64];
            r_m2_ne   <= f_mul_fin(r_m1_pa, TRIG_FRAC);
            r_m2_ncl  <= f_mul_fin(r_m1_pb, TRIG_FRAC);
            r_m2_n    <= r_m1_n;
            r_m2_hq   <= r_m1_hq;
            r_m2_trig <= r_m1_trig;
            r_m3_p0   <= f_mul_pp(r_m2_ncl, r_m2_trig.co);
            r_m3_p1   <= f_mul_pp(r_m2_ncl, r_m2_trig.so);
            r_m3_p2   <= f_mul_pp(r_m2_n - r_m2_ne + r_m2_hq, r_m2_trig.sl);
            r_m3_trig <= r_m2_trig;
            r_m4_vec.x <= f_mul_fin(r_m3_p0, TRIG_FRAC);
            r_m4_vec.y <= f_mul_fin(r_m3_p1, TRIG_FRAC);
            r_m4_vec.z <= f_mul_fin(r_m3_p2, TRIG_FRAC);
            r_m4_trig <= r_m3_trig;
        end
    end

    assign o_vec  = r_m4_vec;
    assign o_trig = r_m4_trig;

endmodule

// ===== sv/geodetic_to_local_enu.sv =====
// top level: anchor registers, two earth-centred pipelines, rotation into east/north/up
// depends on g2e_pkg and g2e_ecef
//
// Takes one position word per cycle while the output is not stalled and returns
// its east/north/up offsets, in millimetres, from a pipeline whose depth is set by the
// cordic rotation stages and by the 64-stage square root and
// 64-stage divide that form the normal radius. The anchor goes through a second copy
// of the same pipeline in lockstep with each word, so anchor writes take effect for
// the next word accepted. Offsets beyond 32 bits clamp and raise o_range_overflow.
// A stalled output holds the whole pipeline; nothing is dropped or repeated.
module geodetic_to_local_enu import g2e_pkg::*; #(
    parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF,
    parameter int CORDIC_STAGES   = CORDIC_STAGES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic signed [31:0] i_pos_lon,
    input  logic signed [30:0] i_pos_lat,
    input  logic signed [31:0] i_pos_height,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [31:0] o_east_mm,
    output logic signed [31:0] o_north_mm,
    output logic signed [31:0] o_up_mm,
    output logic               o_range_overflow,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);

    localparam int LAT = f_ecef_lat(CORDIC_STAGES) + TOP_STAGES;

    logic signed [31:0] r_anchor_lon;
    logic signed [30:0] r_anchor_lat;
    logic signed [31:0] r_anchor_height;
    logic               r_vld [0:LAT-1];
    logic               en;

    assign en          = !r_vld[LAT-1] || i_out_ready;
    assign o_in_ready  = en;
    assign o_out_valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_anchor_lon    <= '0;
            r_anchor_lat    <= '0;
            r_anchor_height <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_ANCHOR_LON:    r_anchor_lon    <= i_cfg_data;
                REG_ANCHOR_LAT:    r_anchor_lat    <= i_cfg_data[30:0];
                REG_ANCHOR_HEIGHT: r_anchor_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LAT; i++) begin
                r_vld[i] <= 1'b0;
            end
        end else if (en) begin
            r_vld[0] <= i_in_valid;
            for (int i = 1; i < LAT; i++) begin
                r_vld[i] <= r_vld[i-1];
            end
        end
    end

    t_vec  pos_vec, anc_vec;
    t_trig pos_trig, anc_trig;

    g2e_ecef #(
        .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS),
        .CORDIC_STAGES  (CORDIC_STAGES)
    ) u_pos (
        .i_clk    (i_clk),
        .i_en     (en),
        .i_lon    (i_pos_lon),
        .i_lat    (i_pos_lat),
        .i_height (i_pos_height),
        .o_vec    (pos_vec),
        .o_trig   (pos_trig)
    );

    g2e_ecef #(
        .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS),
        .CORDIC_STAGES  (CORDIC_STAGES)
    ) u_anchor (
        .i_clk    (i_clk),
        .i_en     (en),
        .i_lon    (r_anchor_lon),
        .i_lat    (r_anchor_lat),
        .i_height (r_anchor_height),
        .o_vec    (anc_vec),
        .o_trig   (anc_trig)
    );

    // rotation: sc, ss, cc, cs are sl0*co0, sl0*so0, cl0*co0, cl0*so0
    t_vec               r_t1_d, r_t2_d;
    t_trig              r_t1_trig, r_t2_trig;
    t_pp                r_t1_pp [0:3];
    logic signed [63:0] r_t2_m  [0:3];
    t_pp                r_t3_pp [0:7];
    logic signed [63:0] r_t4_p  [0:7];
    logic signed [63:0] r_t5_e, r_t5_n, r_t5_u;
    logic signed [31:0] r_east, r_north, r_up;
    logic               r_ovf;

    function automatic logic signed [47:0] f_to_mm(input logic signed [63:0] v);
        logic signed [63:0] t;
        t = v + 64'sd32768;
        return 48'(t >>> LEN_FRAC);
    endfunction

    logic signed [47:0] mm_e, mm_n, mm_u;
    logic               sat_e, sat_n, sat_u;
    logic signed [31:0] cl_e, cl_n, cl_u;

    assign mm_e = f_to_mm(r_t5_e);
    assign mm_n = f_to_mm(r_t5_n);
    assign mm_u = f_to_mm(r_t5_u);

    function automatic logic signed [31:0] f_clamp(input logic signed [47:0] m);
        if (m > 48'sd2147483647) begin
            return 32'h7fffffff;
        end else if (m < -48'sd2147483648) begin
            return 32'h80000000;
        end
        return m[31:0];
    endfunction

    assign sat_e = (mm_e > 48'sd2147483647) || (mm_e < -48'sd2147483648);
    assign sat_n = (mm_n > 48'sd2147483647) || (mm_n < -48'sd2147483648);
    assign sat_u = (mm_u > 48'sd2147483647) || (mm_u < -48'sd2147483648);
    assign cl_e  = f_clamp(mm_e);
    assign cl_n  = f_clamp(mm_n);
    assign cl_u  = f_clamp(mm_u);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_t1_d.x   <= pos_vec.x - anc_vec.x;
            r_t1_d.y   <= pos_vec.y - anc_vec.y;
            r_t1_d.z   <= pos_vec.z - anc_vec.z;
            r_t1_trig  <= anc_trig;
            r_t1_pp[0] <= f_mul_pp(anc_trig.sl, anc_trig.co);
            r_t1_pp[1] <= f_mul_pp(anc_trig.sl, anc_trig.so);
            r_t1_pp[2] <= f_mul_pp(anc_trig.cl, anc_trig.co);
            r_t1_pp[3] <= f_mul_pp(anc_trig.cl, anc_trig.so);

            for (int i = 0; i < 4; i++) begin
                r_t2_m[i] <= f_mul_fin(r_t1_pp[i], TRIG_FRAC);
            end
            r_t2_d    <= r_t1_d;
            r_t2_trig <= r_t1_trig;

            r_t3_pp[0] <= f_mul_pp(r_t2_trig.so, r_t2_d.x);
            r_t3_pp[1] <= f_mul_pp(r_t2_trig.co, r_t2_d.y);
            r_t3_pp[2] <= f_mul_pp(r_t2_m[0], r_t2_d.x);
            r_t3_pp[3] <= f_mul_pp(r_t2_m[1], r_t2_d.y);
            r_t3_pp[4] <= f_mul_pp(r_t2_trig.cl, r_t2_d.z);
            r_t3_pp[5] <= f_mul_pp(r_t2_m[2], r_t2_d.x);
            r_t3_pp[6] <= f_mul_pp(r_t2_m[3], r_t2_d.y);
            r_t3_pp[7] <= f_mul_pp(r_t2_trig.sl, r_t2_d.z);

            for (int i = 0; i < 8; i++) begin
                r_t4_p[i] <= f_mul_fin(r_t3_pp[i], TRIG_FRAC);
            end

            r_t5_e <= r_t4_p[1] - r_t4_p[0];
            r_t5_n <= r_t4_p[4] - r_t4_p[2] - r_t4_p[3];
            r_t5_u <= r_t4_p[5] + r_t4_p[6] + r_t4_p[7];

            r_east  <= cl_e;
            r_north <= cl_n;
            r_up    <= cl_u;
            r_ovf   <= sat_e || sat_n || sat_u;
        end
    end

    assign o_east_mm        = r_east;
    assign o_north_mm       = r_north;
    assign o_up_mm          = r_up;
    assign o_range_overflow = r_ovf;

    // a waiting result blocks new words
    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |-> !o_in_ready)
        else $error("input taken while output stalled");

    a_cfg_lon: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_we && i_cfg_index == REG_ANCHOR_LON) |=> (r_anchor_lon == $past(i_cfg_data)))
        else $error("anchor longitude write lost");

    a_cfg_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_we && i_cfg_index == REG_ANCHOR_LAT)
        |=> (r_anchor_lat == $past(i_cfg_data[30:0])))
        else $error("anchor latitude write lost");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

// ===== tb/sv/geodetic_to_local_enu_tb.sv =====
// self-checking testbench for geodetic_to_local_enu: fixed-point enu predictor,
// random handshake idling, anchor register sweeps and a long output hold-off
// depends on g2e_pkg and the geodetic_to_local_enu rtl
module geodetic_to_local_enu_tb import g2e_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic signed [63:0] s64;

    typedef struct packed {
        logic signed [31:0] east;
        logic signed [31:0] north;
        logic signed [31:0] up;
        logic               ovf;
    } t_enu;

    localparam int  FRAC      = 23;
    localparam int  STAGES    = 32;
    localparam int  Q_TRIG    = 60;
    localparam int  Q_LEN     = 16;
    localparam int  DRAIN_CYC = 400;
    localparam int  HOLD_CYC  = 600;
    localparam longint LIMIT  = 2000000;
    localparam longint LON_MAX = 1509949440;
    localparam longint LAT_MAX = 754974720;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    logic signed [31:0] i_pos_lon;
    logic signed [30:0] i_pos_lat;
    logic signed [31:0] i_pos_height;
    logic               o_out_valid;
    logic               i_out_ready;
    logic signed [31:0] o_east_mm;
    logic signed [31:0] o_north_mm;
    logic signed [31:0] o_up_mm;
    logic               o_range_overflow;
    logic               i_cfg_we;
    logic [1:0]         i_cfg_index;
    logic [31:0]        i_cfg_data;

    geodetic_to_local_enu dut (.*);

    // predictor constants and anchor copy
    s64 atan_tab [64];
    s64 rad_deg;
    s64 gain_k;
    s64 e2_q60;
    s64 anc_lon;
    s64 anc_lat;
    s64 anc_h;

    t_enu   pending_enu [$];
    int     errors;
    int     words_sent;
    int     words_checked;
    longint cycles;
    bit     idle_on;
    int     stall_left;
    int     hold_left;
    bit     hold_request;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles, %0d words pending", cycles, pending_enu.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ---------------- predictor ----------------
    function automatic s64 mulr(s64 a, s64 b, int s);
        logic [63:0]  ma;
        logic [63:0]  mb;
        logic [127:0] p;
        logic [63:0]  r;
        ma = a[63] ? 64'(-a) : 64'(a);
        mb = b[63] ? 64'(-b) : 64'(b);
        p  = {64'b0, ma} * {64'b0, mb};
        p  = p + (128'd1 << (s - 1));
        r  = 64'(p >> s);
        return (a[63] ^ b[63]) ? s64'(-r) : s64'(r);
    endfunction

    function automatic logic [63:0] root128(logic [127:0] x);
        logic [63:0] r;
        logic [63:0] t;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            t = r | (64'd1 << b);
            if (({64'b0, t} * {64'b0, t}) <= x) r = t;
        end
        return r;
    endfunction

    function automatic longint arctan_recip(longint n);
        longint p;
        longint sum;
        longint k;
        longint t;
        p = (longint'(1) << Q_TRIG) / n;
        sum = 0;
        k = 0;
        while (p != 0) begin
            t = p / (2 * k + 1);
            sum = k[0] ? sum - t : sum + t;
            p = p / (n * n);
            k++;
        end
        return sum;
    endfunction

    task automatic init_tables();
        logic [63:0] g;
        logic [63:0] sg;
        longint sum;
        longint k;
        longint t;
        int e;
        atan_tab[0] = 4 * arctan_recip(5) - arctan_recip(239);
        for (int i = 1; i < 64; i++) begin
            sum = 0;
            k = 0;
            e = Q_TRIG - i;
            while (e >= 0) begin
                t = (longint'(1) << e) / (2 * k + 1);
                sum = k[0] ? sum - t : sum + t;
                k++;
                e = Q_TRIG - i * int'(2 * k + 1);
            end
            atan_tab[i] = sum;
        end
        rad_deg = (4 * atan_tab[0]) / 180;
        g = 64'd1 << Q_TRIG;
        for (int i = 0; i < STAGES; i++) g = g + (g >> (2 * i));
        sg = root128({64'b0, g} << 60);
        gain_k = s64'(64'((128'd1 << 120) / {64'b0, sg}));
        e2_q60 = s64'(64'(({64'b0, 64'd595514000} << 60) / 128'd88957238049));
    endtask

    task automatic rotate_trig(input s64 d, output s64 s, output s64 c);
        s64 full;
        s64 half;
        s64 quarter;
        s64 r;
        s64 x;
        s64 y;
        s64 z;
        s64 dx;
        s64 dy;
        bit flip;
        full = s64'(360) << FRAC;
        half = s64'(180) << FRAC;
        quarter = s64'(90) << FRAC;
        flip = 1'b0;
        r = d % full;
        if (r > half) r -= full;
        else if (r <= -half) r += full;
        // fold into the right half-plane, cosine changes sign
        if (r > quarter) begin
            r = half - r;
            flip = 1'b1;
        end else if (r < -quarter) begin
            r = -half - r;
            flip = 1'b1;
        end
        z = mulr(r, rad_deg, FRAC);
        x = gain_k;
        y = 0;
        for (int i = 0; i < STAGES; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= atan_tab[i];
            end else begin
                x += dx; y -= dy; z += atan_tab[i];
            end
        end
        s = y;
        c = flip ? -x : x;
    endtask

    task automatic geo_to_ecef(input s64 lon, input s64 lat, input s64 h,
                               output s64 vx, output s64 vy, output s64 vz,
                               output s64 sl, output s64 cl, output s64 so, output s64 co);
        s64 w;
        s64 nr;
        s64 hq;
        s64 nh;
        logic [63:0] sw;
        rotate_trig(lat, sl, cl);
        rotate_trig(lon, so, co);
        w  = (s64'(1) << Q_TRIG) - mulr(e2_q60, mulr(sl, sl, Q_TRIG), Q_TRIG);
        sw = root128({64'b0, w} << 60);
        nr = s64'(64'({64'd6378137000 << 12, 64'b0} / {64'b0, sw}));
        hq = h * 65536;
        nh = nr + hq;
        vx = mulr(mulr(nh, cl, Q_TRIG), co, Q_TRIG);
        vy = mulr(mulr(nh, cl, Q_TRIG), so, Q_TRIG);
        vz = mulr(nr - mulr(nr, e2_q60, Q_TRIG) + hq, sl, Q_TRIG);
    endtask

    function automatic logic signed [31:0] clamp_mm(s64 v, ref logic ovf);
        s64 m;
        m = (v + (s64'(1) << (Q_LEN - 1))) >>> Q_LEN;
        if (m > 64'sd2147483647) begin
            ovf = 1'b1;
            return 32'sh7fffffff;
        end
        if (m < -64'sd2147483648) begin
            ovf = 1'b1;
            return 32'sh80000000;
        end
        return m[31:0];
    endfunction

    task automatic predict_enu(input s64 lon, input s64 lat, input s64 h, output t_enu res);
        s64 px, py, pz, ax, ay, az, dx, dy, dz;
        s64 sl, cl, so, co, sl0, cl0, so0, co0;
        s64 e, n, u;
        logic ovf;
        geo_to_ecef(lon, lat, h, px, py, pz, sl, cl, so, co);
        geo_to_ecef(anc_lon, anc_lat, anc_h, ax, ay, az, sl0, cl0, so0, co0);
        dx = px - ax;
        dy = py - ay;
        dz = pz - az;
        e = -mulr(so0, dx, Q_TRIG) + mulr(co0, dy, Q_TRIG);
        n = -mulr(mulr(sl0, co0, Q_TRIG), dx, Q_TRIG)
            - mulr(mulr(sl0, so0, Q_TRIG), dy, Q_TRIG) + mulr(cl0, dz, Q_TRIG);
        u = mulr(mulr(cl0, co0, Q_TRIG), dx, Q_TRIG)
            + mulr(mulr(cl0, so0, Q_TRIG), dy, Q_TRIG) + mulr(sl0, dz, Q_TRIG);
        ovf = 1'b0;
        res.east  = clamp_mm(e, ovf);
        res.north = clamp_mm(n, ovf);
        res.up    = clamp_mm(u, ovf);
        res.ovf   = ovf;
    endtask

    // ---------------- checking ----------------
    task automatic report(input string what, input longint got, input longint want);
        errors++;
        $display("mismatch %s at cycle %0d: got %0d want %0d", what, cycles, got, want);
    endtask

    always @(posedge i_clk) begin
        t_enu want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_enu.size() == 0) begin
                report("unexpected word", 0, 0);
            end else begin
                want = pending_enu.pop_front();
                if (o_east_mm !== want.east) report("east_mm", o_east_mm, want.east);
                if (o_north_mm !== want.north) report("north_mm", o_north_mm, want.north);
                if (o_up_mm !== want.up) report("up_mm", o_up_mm, want.up);
                if (o_range_overflow !== want.ovf)
                    report("range_overflow", o_range_overflow, want.ovf);
                words_checked++;
            end
            stall_left = idle_on ? $urandom_range(0, 4) : 0;
        end
    end

    // output side: random stalls plus one long hold-off, requested by test_output_hold
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                hold_left = HOLD_CYC;
                hold_request = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready = 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                i_out_ready = 1'b0;
            end else begin
                i_out_ready = 1'b1;
            end
        end
    end

    // ---------------- stimulus ----------------
    task automatic send_pos(input longint lon, input longint lat, input longint h);
        int gap;
        t_enu want;
        gap = idle_on ? $urandom_range(0, 4) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_pos_lon = lon[31:0];
        i_pos_lat = lat[30:0];
        i_pos_height = h[31:0];
        i_in_valid = 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        predict_enu(s64'(i_pos_lon), s64'(i_pos_lat), s64'(i_pos_height), want);
        pending_enu = {pending_enu, want};
        words_sent++;
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (pending_enu.size() != 0) @(negedge i_clk);
    endtask

    task automatic write_anchor(input logic [1:0] idx, input logic [31:0] data);
        wait_drained();
        i_cfg_we = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = data;
        case (idx)
            REG_ANCHOR_LON:    anc_lon = s64'(signed'(data));
            REG_ANCHOR_LAT:    anc_lat = s64'(signed'(data[30:0]));
            REG_ANCHOR_HEIGHT: anc_h = s64'(signed'(data));
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic set_anchor(input longint lon, input longint lat, input longint h);
        write_anchor(REG_ANCHOR_LON, lon[31:0]);
        write_anchor(REG_ANCHOR_LAT, {$urandom_range(0, 1) == 1, lat[30:0]});
        write_anchor(REG_ANCHOR_HEIGHT, h[31:0]);
    endtask

    function automatic longint span(longint lim);
        return longint'($urandom_range(0, 32'(2 * lim))) - lim;
    endfunction

    // a point within about 0.12 degrees and 10 km in height of the anchor, or any bit pattern
    task automatic send_random(input bit raw);
        if (raw)
            send_pos(longint'($urandom()), longint'($urandom()), longint'($urandom()));
        else
            send_pos(anc_lon + $urandom_range(0, 2000000) - 1000000,
                     anc_lat + $urandom_range(0, 2000000) - 1000000,
                     anc_h + $urandom_range(0, 20000000) - 10000000);
    endtask

    task automatic test_zero_anchor_edges();
        send_pos(0, 0, 0);   // position on the anchor
        send_pos(LON_MAX, LAT_MAX, 0);
        send_pos(-LON_MAX, -LAT_MAX, 0);
        send_pos(LON_MAX, 0, 0);
        send_pos(0, LAT_MAX, 2147483647);
        send_pos(0, -LAT_MAX, -2147483648);
        // patterns outside the nominal range wrap around the circle
        send_pos(-2147483648, -1073741824, 0);
        send_pos(2147483647, 1073741823, 2147483647);
        send_pos(-1, -1, -1);
        send_pos(1, 1, 1);
        send_pos(LON_MAX / 2, LAT_MAX / 2, 1000);
        send_pos(-LON_MAX / 2, LAT_MAX / 2 + 1, -1000);
    endtask

    task automatic test_anchor_extremes();
        set_anchor(LON_MAX, LAT_MAX, 2147483647);
        send_pos(LON_MAX, LAT_MAX, 2147483647);
        send_pos(-LON_MAX, -LAT_MAX, -2147483648);
        send_pos(LON_MAX, LAT_MAX - 1000, 2147483000);
        set_anchor(-LON_MAX, -LAT_MAX, -2147483648);
        send_pos(-LON_MAX, -LAT_MAX, -2147483648);
        send_pos(LON_MAX, LAT_MAX, 2147483647);
        send_pos(-LON_MAX + 5000, -LAT_MAX + 5000, -2147480000);
        set_anchor(0, 0, 0);
    endtask

    task automatic test_output_hold();
        set_anchor(span(LON_MAX), span(LAT_MAX), $urandom_range(0, 2000000));
        hold_request = 1'b1;
        for (int i = 0; i < 300; i++) send_random($urandom_range(0, 9) == 0);
        wait_drained();
    endtask

    task automatic test_random_phases();
        for (int ph = 0; ph < 10; ph++) begin
            idle_on = (ph != 3);
            if (ph == 6) set_anchor(span(LON_MAX), span(LAT_MAX), longint'($urandom()));
            else set_anchor(span(LON_MAX), span(LAT_MAX), $urandom_range(0, 9000000) - 500000);
            for (int i = 0; i < 125; i++) send_random($urandom_range(0, 99) < 15);
        end
        idle_on = 1'b1;
    endtask

    initial begin
        errors = 0;
        words_sent = 0;
        words_checked = 0;
        cycles = 0;
        idle_on = 1'b1;
        stall_left = 0;
        hold_left = 0;
        hold_request = 1'b0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_pos_lon = '0;
        i_pos_lat = '0;
        i_pos_height = '0;
        i_cfg_we = 1'b0;
        i_cfg_index = REG_ANCHOR_LON;
        i_cfg_data = '0;
        anc_lon = 0;
        anc_lat = 0;
        anc_h = 0;
        init_tables();
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_zero_anchor_edges();
        test_anchor_extremes();
        test_output_hold();
        test_random_phases();

        wait_drained();
        repeat (DRAIN_CYC) @(posedge i_clk);
        $display("sent %0d positions, checked %0d enu words over 14 anchor settings",
                 words_sent, words_checked);
        $display("covered edge angles, wrapped patterns, saturation and a %0d cycle hold-off",
                 HOLD_CYC);
        if (errors == 0 && pending_enu.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("%0d mismatches, %0d words missing", errors, pending_enu.size());
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
